FILE: rtl/core/lrc_pkg.sv
// Package for the LRU result cache: payload structs, action codes, control types.
// No dependencies.
package lrc_pkg;

    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;
    localparam logic [31:0] CNT_MAX   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] key_w0;
        logic [63:0] key_w1;
        logic [63:0] key_w2;
        logic [63:0] key_w3;
        logic        new_value;
    } t_in_item;

    typedef struct packed {
        logic        hit;
        logic        stored_value;
        logic        evicted;
        logic [6:0]  occupancy;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture input beat
        logic execute;  // apply state update, drive result
    } t_lrc_cmd;

endpackage

FILE: rtl/core/lrc_datapath.sv
// Datapath for the LRU result cache: tag store, ranks, parallel match, counters.
// Depends on lrc_pkg.
module lrc_datapath
    import lrc_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_lrc_cmd  i_cmd,
    input  t_in_item  i_item,
    input  logic [6:0] i_capacity,
    output t_out_item o_result
);
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    logic [255:0]   r_key   [ENTRIES];
    logic           r_vbit  [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [IW-1:0]  r_rank  [ENTRIES];
    logic [CW-1:0]  r_count;
    logic [31:0]    r_hits, r_misses;
    t_in_item       r_item;
    t_out_item      r_result;

    // stage 1 registers: match and victim info
    logic [ENTRIES-1:0] r_match;
    logic [ENTRIES-1:0] r_oldest;
    logic [ENTRIES-1:0] r_free_first;

    logic [ENTRIES-1:0] n_match, n_oldest, n_free_first;
    logic [255:0] l_key;

    assign l_key = {r_item.key_w3, r_item.key_w2, r_item.key_w1, r_item.key_w0};

    always_comb begin
        logic seen;
        seen = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            n_match[i]  = r_valid[i] && (r_key[i] == l_key);
            n_oldest[i] = r_valid[i] && (r_rank[i] == IW'(r_count - CW'(1)));
            n_free_first[i] = !r_valid[i] && !seen;
            if (!r_valid[i]) seen = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_item <= i_item;
        r_match      <= n_match;
        r_oldest     <= n_oldest;
        r_free_first <= n_free_first;
    end

    logic        l_hit, l_sval, l_full, l_ev;
    logic [IW-1:0] l_hrank;
    logic [CW:0] l_lim;
    t_out_item   n_result;

    always_comb begin
        l_hit   = |r_match;
        l_sval  = 1'b0;
        l_hrank = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (r_match[i]) begin
                l_sval  = r_vbit[i];
                l_hrank = r_rank[i];
            end
        end
        l_lim  = ({1'b0, i_capacity} > (CW+1)'(ENTRIES)) ? (CW+1)'(ENTRIES)
                                                       : (CW+1)'(i_capacity);
        l_full = ({1'b0, r_count} >= l_lim);
        l_ev   = l_full && (r_count != '0);
    end

    always_comb begin
        n_result            = '0;
        n_result.occupancy  = 7'(r_count);
        n_result.hit_total  = r_hits;
        n_result.miss_total = r_misses;
        unique case (r_item.action)
            ACT_LOOKUP: begin
                n_result.hit          = l_hit;
                n_result.stored_value = l_hit & l_sval;
                if (l_hit && r_hits != CNT_MAX) n_result.hit_total = r_hits + 32'd1;
                if (!l_hit && r_misses != CNT_MAX) n_result.miss_total = r_misses + 32'd1;
            end
            ACT_INSERT: begin
                n_result.hit     = l_hit;
                n_result.evicted = !l_hit && l_ev;
                if (!l_hit && !l_ev) n_result.occupancy = 7'(r_count + CW'(1));
            end
            ACT_CLEAR: n_result.occupancy = '0;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_count  <= '0;
            r_hits   <= '0;
            r_misses <= '0;
            r_result <= '0;
            for (int i = 0; i < ENTRIES; i++) r_rank[i] <= '0;
        end else if (i_cmd.execute) begin
            r_result <= n_result;
            unique case (r_item.action)
                ACT_LOOKUP: begin
                    if (l_hit) begin
                        if (r_hits != CNT_MAX) r_hits <= r_hits + 32'd1;
                        for (int i = 0; i < ENTRIES; i++)
                            if (r_match[i]) r_rank[i] <= '0;
                            else if (r_valid[i] && r_rank[i] < l_hrank)
                                r_rank[i] <= r_rank[i] + IW'(1);
                    end else if (r_misses != CNT_MAX) begin
                        r_misses <= r_misses + 32'd1;
                    end
                end
                ACT_INSERT: begin
                    if (l_hit) begin
                        for (int i = 0; i < ENTRIES; i++)
                            if (r_match[i]) begin
                                r_rank[i] <= '0;
                                r_vbit[i] <= r_item.new_value;
                            end else if (r_valid[i] && r_rank[i] < l_hrank)
                                r_rank[i] <= r_rank[i] + IW'(1);
                    end else begin
                        // evict oldest (freed slot may be reused only if no lower free slot)
                        logic [ENTRIES-1:0] fr;
                        logic sn;
                        logic [ENTRIES-1:0] vv;
                        vv = r_valid & ~(l_ev ? r_oldest : '0);
                        sn = 1'b0;
                        for (int i = 0; i < ENTRIES; i++) begin
                            fr[i] = !vv[i] && !sn;
                            if (!vv[i]) sn = 1'b1;
                        end
                        r_count <= l_ev ? r_count : r_count + CW'(1);
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (fr[i]) begin
                                r_key[i]  <= l_key;
                                r_vbit[i] <= r_item.new_value;
                                r_rank[i] <= '0;
                                r_valid[i] <= 1'b1;
                            end else if (vv[i]) begin
                                r_rank[i] <= r_rank[i] + IW'(1);
                                r_valid[i] <= 1'b1;
                            end else begin
                                r_valid[i] <= 1'b0;
                                r_rank[i]  <= '0;
                            end
                        end
                    end
                end
                ACT_CLEAR: begin
                    r_valid <= '0;
                    r_count <= '0;
                    for (int i = 0; i < ENTRIES; i++) r_rank[i] <= '0;
                end
                default: ;
            endcase
        end
    end

    assign o_result = r_result;

endmodule

FILE: rtl/core/lrc_ctrl.sv
// Controller for the LRU result cache: load, match, execute sequencing.
// Depends on lrc_pkg.
module lrc_ctrl
    import lrc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    output logic     o_busy,
    output logic     o_done,
    output t_lrc_cmd o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_MATCH = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_done;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_start) n_state = S_MATCH;
            S_MATCH: n_state = S_EXEC;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_EXEC);
        end
    end

    assign o_cmd.load    = (r_state == S_IDLE) && i_start;
    assign o_cmd.execute = (r_state == S_EXEC);
    assign o_busy        = (r_state != S_IDLE);
    assign o_done        = r_done;

endmodule

FILE: rtl/core/lru_result_cache.sv
// Top level of the LRU result cache: APB capacity register, controller, datapath.
// Depends on lrc_pkg, lrc_ctrl, lrc_datapath.
//
// Usage: raise start with an item on i_item; the beat is taken at the edge
// where busy is low. o_valid is high for one cycle with o_result, once the
// item has passed the match and execute states after that edge.
// Each item goes through load, parallel tag match over all entries
// (registered), then the rank and store update. Busy holds off new items
// meanwhile. The receiver cannot stall; o_valid flags a result for one cycle.
// The APB port holds the capacity register at address 0 (reset 64);
// write it only while idle. Reset clears valid bits, ranks, occupancy and
// counters at once; no clearing pass is needed.
module lru_result_cache
    import lrc_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_valid,
    output t_out_item o_result,
    input  logic      psel,
    input  logic      penable,
    input  logic      pwrite,
    input  logic      paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic      pready
);
    logic [6:0] r_capacity;
    t_lrc_cmd   l_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_capacity <= 7'd64;
        else if (psel && penable && pwrite && !paddr) r_capacity <= pwdata[6:0];
    end

    assign pready = 1'b1;
    assign prdata = paddr ? 32'd0 : {25'd0, r_capacity};

    lrc_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_start(start), .o_busy(busy), .o_done(o_valid), .o_cmd(l_cmd)
    );

    lrc_datapath #(.ENTRIES(ENTRIES)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(l_cmd), .i_item, .i_capacity(r_capacity), .o_result
    );

endmodule
